// ----- hdl/goe_pkg.sv -----
`timescale 1ns / 1ps
// goe_pkg: shared widths, fixed-point constants and the 2^-f interpolation table
// for the gaussian orbital evaluator; no dependencies

package goe_pkg;

  // table geometry
  localparam int EXP_TABLE_ENTRIES = 256;
  localparam int IDX_W = $clog2(EXP_TABLE_ENTRIES);
  localparam int NW = $clog2(EXP_TABLE_ENTRIES + 1);
  localparam int POS_W = 32 + NW;
  localparam int TAB_W = 33;
  localparam int SERIES_TERMS = 40;

  // datapath widths
  localparam int D_W = 32;
  localparam int SQ_W = 48;
  localparam int R2_W = 50;
  localparam int PF_W = 82;
  localparam int T_W = 37;
  localparam int U_W = 38;
  localparam int E_W = 33;
  localparam int W_W = 38;
  localparam int AC_W = 64;

  // exp unit pipeline depth in stages
  localparam int EXP_STAGES = 7;

  // fixed-point constants
  localparam logic [63:0] ONE_Q32 = 64'd1 << 32;
  localparam logic [63:0] HALF_Q32 = 64'd1 << 31;
  localparam logic [63:0] LN2_Q32 = 64'd2977044472;
  localparam logic [63:0] LOG2E_Q32 = 64'd6196328019;
  localparam logic [30:0] LOG2E_LO = 31'(LOG2E_Q32 - ONE_Q32);
  localparam logic [63:0] T_LIMIT = 64'd23 << 32;
  localparam logic [W_W-1:0] THREE_Q32 = W_W'(3) << 32;

  typedef logic [EXP_TABLE_ENTRIES:0][TAB_W-1:0] pow2_tab_t;

  // 2^(-k/N) in Q1.32 by an alternating series of exp(-k*ln2/N)
  function automatic pow2_tab_t build_pow2_tab();
    pow2_tab_t tab;
    logic [63:0] y;
    logic [63:0] sum;
    logic [63:0] term;
    tab = '0;
    for (int k = 0; k <= EXP_TABLE_ENTRIES; k++) begin
      y = (64'(k) * LN2_Q32 + 64'(EXP_TABLE_ENTRIES / 2)) / 64'(EXP_TABLE_ENTRIES);
      sum = ONE_Q32;
      term = ONE_Q32;
      for (int i = 1; i <= SERIES_TERMS; i++) begin
        if (term != 64'd0) begin
          term = ((term * y + HALF_Q32) >> 32) / 64'(i);
          if (i[0]) begin
            sum = sum - term;
          end else begin
            sum = sum + term;
          end
        end
      end
      tab[k] = sum[TAB_W-1:0];
    end
    return tab;
  endfunction

  localparam pow2_tab_t POW2_TAB = build_pow2_tab();

endpackage

// ----- hdl/goe_exp_unit.sv -----
`timescale 1ns / 1ps
// goe_exp_unit: seven-stage pipelined exp(-t), t in Q.32, answer in Q1.32
// depends on goe_pkg (widths, log2e split, 2^-f table); stage enables come from the top

module goe_exp_unit (
  input  logic                             clk,
  input  logic [goe_pkg::EXP_STAGES-1:0]   adv,
  input  logic [goe_pkg::T_W-1:0]          t,
  output logic [goe_pkg::E_W-1:0]          e
);

  // stage 1: t * log2e partial products
  logic [goe_pkg::T_W-1:0]   t1_r;
  logic [62:0]               q0_r, q0_nxt;
  logic [35:0]               q1_r, q1_nxt;
  // stage 2: integer and fraction of u
  logic [goe_pkg::U_W-1:0]   u_nxt;
  logic                      big2_r;
  logic [4:0]                n2_r;
  logic [31:0]               f2_r;
  // stage 3: table position
  logic [goe_pkg::POS_W-1:0] pos_nxt;
  logic [goe_pkg::IDX_W-1:0] idx3_r;
  logic [31:0]               fr3_r;
  logic [4:0]                n3_r;
  logic                      big3_r;
  // stage 4: table read
  logic [goe_pkg::NW-1:0]    ia_nxt, ib_nxt;
  logic [goe_pkg::TAB_W-1:0] ta_nxt, tb_nxt, tdiff_nxt;
  logic [goe_pkg::TAB_W-1:0] a4_r;
  logic [31:0]               diff4_r;
  logic [31:0]               fr4_r;
  logic [4:0]                n4_r;
  logic                      big4_r;
  // stage 5: interpolation product
  logic [63:0]               prod5_r, prod5_nxt;
  logic [goe_pkg::TAB_W-1:0] a5_r;
  logic [4:0]                n5_r;
  logic                      big5_r;
  // stage 6: mantissa
  logic [64:0]               rnd_nxt;
  logic [goe_pkg::TAB_W-1:0] m6_r, m6_nxt;
  logic [4:0]                n6_r;
  logic                      big6_r;
  // stage 7: rounded shift by the integer part
  logic [34:0]               sh_nxt, esh_nxt;
  logic [goe_pkg::E_W-1:0]   e_r, e_nxt;

  always_comb begin
    q0_nxt = 63'(t[31:0]) * 63'(goe_pkg::LOG2E_LO);
    q1_nxt = 36'(t[goe_pkg::T_W-1:32]) * 36'(goe_pkg::LOG2E_LO);

    u_nxt = goe_pkg::U_W'(t1_r) + goe_pkg::U_W'(q1_r) + goe_pkg::U_W'(q0_r[62:32]);

    pos_nxt = goe_pkg::POS_W'(f2_r) * goe_pkg::POS_W'(goe_pkg::EXP_TABLE_ENTRIES);

    ia_nxt = goe_pkg::NW'(idx3_r);
    ib_nxt = ia_nxt + goe_pkg::NW'(1);
    ta_nxt = goe_pkg::POW2_TAB[ia_nxt];
    tb_nxt = goe_pkg::POW2_TAB[ib_nxt];
    tdiff_nxt = ta_nxt - tb_nxt;

    prod5_nxt = 64'(diff4_r) * 64'(fr4_r);

    rnd_nxt = 65'(prod5_r) + 65'(goe_pkg::HALF_Q32);
    m6_nxt = a5_r - rnd_nxt[64:32];

    // (2m + 2^n) >> (n+1) is m >> n rounded half up, n = 0 included
    sh_nxt = 35'({m6_r, 1'b0}) + (35'd1 << n6_r);
    esh_nxt = sh_nxt >> ({1'b0, n6_r} + 6'd1);
    e_nxt = big6_r ? '0 : esh_nxt[goe_pkg::E_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      t1_r <= t;
      q0_r <= q0_nxt;
      q1_r <= q1_nxt;
    end
    if (adv[1]) begin
      big2_r <= u_nxt[goe_pkg::U_W-1];
      n2_r <= u_nxt[36:32];
      f2_r <= u_nxt[31:0];
    end
    if (adv[2]) begin
      idx3_r <= pos_nxt[32 +: goe_pkg::IDX_W];
      fr3_r <= pos_nxt[31:0];
      n3_r <= n2_r;
      big3_r <= big2_r;
    end
    if (adv[3]) begin
      a4_r <= ta_nxt;
      diff4_r <= tdiff_nxt[31:0];
      fr4_r <= fr3_r;
      n4_r <= n3_r;
      big4_r <= big3_r;
    end
    if (adv[4]) begin
      prod5_r <= prod5_nxt;
      a5_r <= a4_r;
      n5_r <= n4_r;
      big5_r <= big4_r;
    end
    if (adv[5]) begin
      m6_r <= m6_nxt;
      n6_r <= n5_r;
      big6_r <= big5_r;
    end
    if (adv[6]) begin
      e_r <= e_nxt;
    end
  end

  assign e = e_r;

endmodule

// ----- hdl/gaussian_orbital_evaluator.sv -----
`timescale 1ns / 1ps
// gaussian_orbital_evaluator: 17-stage pipeline for c*exp(-alpha*r2) and its laplacian form
// depends on goe_pkg and goe_exp_unit
//
//  channel | ports                                             | beat
//  --------+---------------------------------------------------+-------------------------
//  in      | in_valid in_ready in_kind in_px..in_cz in_alpha   | one point and gaussian
//          | in_coef                                           |
//  out     | out_valid out_ready out_result out_saturated      | one Q32.32 result
//
//  one beat enters per cycle while in_ready is high; a beat reaches out_valid
//  through the stage registers: squares, alpha*r2, the exp unit (7 stages), the
//  products with e, and the 64x38 partial-product sum
//  rst_n (synchronous) clears the stage valid bits only
//  a stage holds when it and every stage after it are full and out_ready is
//  low; empty stages keep filling, so bubbles close up under a stall

module gaussian_orbital_evaluator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [31:0] in_px,
  input  logic [31:0] in_py,
  input  logic [31:0] in_pz,
  input  logic [31:0] in_cx,
  input  logic [31:0] in_cy,
  input  logic [31:0] in_cz,
  input  logic [31:0] in_alpha,
  input  logic [31:0] in_coef,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_result,
  output logic        out_saturated
);

  localparam int NS = 17;
  localparam int EXP_FIRST = 5;
  localparam logic [71:0] MAG_POS_LIM = 72'(64'h7FFF_FFFF_FFFF_FFFF);
  localparam logic [71:0] MAG_NEG_LIM = 72'd1 << 63;

  // fields that ride alongside the exp unit
  typedef struct packed {
    logic                      kind;
    logic                      cneg;
    logic [31:0]               cmag;
    logic [goe_pkg::AC_W-1:0]  ac;
    logic [goe_pkg::W_W-1:0]   wmag;
    logic                      wneg;
    logic                      uf;
  } side_t;

  // stage valid bits and advance enables
  logic [NS-1:0] v_r;
  logic [NS-1:0] adv;

  // stage 1: axis deltas, |coef|
  logic [32:0]               dx_nxt, dy_nxt, dz_nxt;
  logic [goe_pkg::D_W-1:0]   s1_dx_r, s1_dy_r, s1_dz_r;
  logic [31:0]               s1_alpha_r, s1_cmag_r;
  logic                      s1_cneg_r, s1_kind_r;
  // stage 2: squares, alpha*|coef|
  logic [63:0]               sqx_nxt, sqy_nxt, sqz_nxt;
  logic [goe_pkg::SQ_W-1:0]  s2_sqx_r, s2_sqy_r, s2_sqz_r;
  logic [31:0]               s2_alpha_r, s2_cmag_r;
  logic [goe_pkg::AC_W-1:0]  s2_ac_r;
  logic                      s2_cneg_r, s2_kind_r;
  // stage 3: r2
  logic [goe_pkg::R2_W-1:0]  s3_r2_r;
  logic [31:0]               s3_alpha_r, s3_cmag_r;
  logic [goe_pkg::AC_W-1:0]  s3_ac_r;
  logic                      s3_cneg_r, s3_kind_r;
  // stage 4: alpha*r2 partial products
  logic [63:0]               s4_plo_r;
  logic [49:0]               s4_phi_r;
  logic [31:0]               s4_cmag_r;
  logic [goe_pkg::AC_W-1:0]  s4_ac_r;
  logic                      s4_cneg_r, s4_kind_r;
  // stage 5: t and underflow
  logic [goe_pkg::PF_W-1:0]  tfull_nxt;
  logic [goe_pkg::T_W-1:0]   s5_t_r;
  logic                      s5_uf_r;
  logic [31:0]               s5_cmag_r;
  logic [goe_pkg::AC_W-1:0]  s5_ac_r;
  logic                      s5_cneg_r, s5_kind_r;
  // side line, weight |2t - 3| computed on entry
  logic [goe_pkg::W_W-1:0]   twot_nxt;
  side_t                     side0_nxt;
  side_t                     side_r [goe_pkg::EXP_STAGES];
  side_t                     sd;
  logic [goe_pkg::E_W-1:0]   e;
  // stage 13: products with e
  logic [63:0]               pk0_nxt;
  logic [63:0]               s13_pk0_r, s13_w0_r;
  logic [37:0]               s13_w1_r;
  logic                      s13_efull_r, s13_zero_r, s13_kind_r, s13_neg_r;
  logic [goe_pkg::W_W-1:0]   s13_wmag_r;
  logic [goe_pkg::AC_W-1:0]  s13_ac_r;
  // stage 14: kind 0 magnitude, rounded weight*e
  logic [63:0]               mag0sum_nxt;
  logic [70:0]               wesum_nxt;
  logic [goe_pkg::W_W-1:0]   we_nxt;
  logic [47:0]               s14_mag0_r;
  logic [goe_pkg::W_W-1:0]   s14_we_r;
  logic [goe_pkg::AC_W-1:0]  s14_ac_r;
  logic                      s14_kind_r, s14_neg_r, s14_zero_r;
  // stage 15: ac*we partial products
  logic [63:0]               s15_pp0_r, s15_pp1_r;
  logic [37:0]               s15_pp2_r, s15_pp3_r;
  logic [47:0]               s15_mag0_r;
  logic                      s15_kind_r, s15_neg_r, s15_zero_r;
  // stage 16: magnitude select
  logic [102:0]              psum_nxt;
  logic [71:0]               s16_mag_r;
  logic                      s16_neg_r, s16_zero_r;
  // stage 17: output register
  logic [63:0]               out_result_r, result_nxt;
  logic                      out_sat_r, sat_nxt;

  // a stage loads when some stage at or after it is empty, or the output drains
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      adv[k] = out_ready || ((v_r | ((NS'(1) << k) - NS'(1))) != '1);
    end
  end

  assign in_ready = adv[0];
  assign out_valid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= (v_r & ~adv) | ({v_r[NS-2:0], in_valid} & adv);
    end
  end

  always_comb begin
    // stage 1
    dx_nxt = {in_px[31], in_px} - {in_cx[31], in_cx};
    dy_nxt = {in_py[31], in_py} - {in_cy[31], in_cy};
    dz_nxt = {in_pz[31], in_pz} - {in_cz[31], in_cz};

    // stage 2: d*d truncated to Q.16
    sqx_nxt = 64'(s1_dx_r) * 64'(s1_dx_r);
    sqy_nxt = 64'(s1_dy_r) * 64'(s1_dy_r);
    sqz_nxt = 64'(s1_dz_r) * 64'(s1_dz_r);

    // stage 5: exact alpha*r2, underflow at 23.0
    tfull_nxt = goe_pkg::PF_W'(s4_plo_r) + (goe_pkg::PF_W'(s4_phi_r) << 32);

    // side line entry
    twot_nxt = {s5_t_r, 1'b0};
    side0_nxt.kind = s5_kind_r;
    side0_nxt.cneg = s5_cneg_r;
    side0_nxt.cmag = s5_cmag_r;
    side0_nxt.ac = s5_ac_r;
    side0_nxt.uf = s5_uf_r;
    side0_nxt.wneg = twot_nxt < goe_pkg::THREE_Q32;
    side0_nxt.wmag = side0_nxt.wneg ? goe_pkg::THREE_Q32 - twot_nxt
                                    : twot_nxt - goe_pkg::THREE_Q32;

    // stage 13: e is at most 1.0, so e = 2^32 is taken as a plain shift
    sd = side_r[goe_pkg::EXP_STAGES-1];
    pk0_nxt = e[32] ? {sd.cmag, 32'd0} : 64'(sd.cmag) * 64'(e[31:0]);

    // stage 14
    mag0sum_nxt = s13_pk0_r + 64'(1 << 15);
    wesum_nxt = 71'(s13_w0_r) + (71'(s13_w1_r) << 32) + 71'(goe_pkg::HALF_Q32);
    we_nxt = s13_efull_r ? s13_wmag_r : wesum_nxt[69:32];

    // stage 16: ac*we rounded half up at bit 31
    psum_nxt = 103'(s15_pp0_r) + (103'(s15_pp1_r) << 32) + (103'(s15_pp2_r) << 32)
             + (103'(s15_pp3_r) << 64) + (103'(1) << 30);

    // stage 17: saturate to Q32.32
    result_nxt = '0;
    sat_nxt = 1'b0;
    if (s16_zero_r) begin
      result_nxt = '0;
    end else if (!s16_neg_r && s16_mag_r > MAG_POS_LIM) begin
      result_nxt = MAG_POS_LIM[63:0];
      sat_nxt = 1'b1;
    end else if (s16_neg_r && s16_mag_r > MAG_NEG_LIM) begin
      result_nxt = MAG_NEG_LIM[63:0];
      sat_nxt = 1'b1;
    end else if (s16_neg_r) begin
      result_nxt = ~s16_mag_r[63:0] + 64'd1;
    end else begin
      result_nxt = s16_mag_r[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_dx_r <= dx_nxt[32] ? 32'(~dx_nxt + 33'd1) : dx_nxt[31:0];
      s1_dy_r <= dy_nxt[32] ? 32'(~dy_nxt + 33'd1) : dy_nxt[31:0];
      s1_dz_r <= dz_nxt[32] ? 32'(~dz_nxt + 33'd1) : dz_nxt[31:0];
      s1_alpha_r <= in_alpha;
      s1_cmag_r <= in_coef[31] ? ~in_coef + 32'd1 : in_coef;
      s1_cneg_r <= in_coef[31];
      s1_kind_r <= in_kind;
    end
    if (adv[1]) begin
      s2_sqx_r <= sqx_nxt[63:16];
      s2_sqy_r <= sqy_nxt[63:16];
      s2_sqz_r <= sqz_nxt[63:16];
      s2_alpha_r <= s1_alpha_r;
      s2_ac_r <= 64'(s1_alpha_r) * 64'(s1_cmag_r);
      s2_cmag_r <= s1_cmag_r;
      s2_cneg_r <= s1_cneg_r;
      s2_kind_r <= s1_kind_r;
    end
    if (adv[2]) begin
      s3_r2_r <= goe_pkg::R2_W'(s2_sqx_r) + goe_pkg::R2_W'(s2_sqy_r)
               + goe_pkg::R2_W'(s2_sqz_r);
      s3_alpha_r <= s2_alpha_r;
      s3_ac_r <= s2_ac_r;
      s3_cmag_r <= s2_cmag_r;
      s3_cneg_r <= s2_cneg_r;
      s3_kind_r <= s2_kind_r;
    end
    if (adv[3]) begin
      s4_plo_r <= 64'(s3_alpha_r) * 64'(s3_r2_r[31:0]);
      s4_phi_r <= 50'(s3_alpha_r) * 50'(s3_r2_r[goe_pkg::R2_W-1:32]);
      s4_ac_r <= s3_ac_r;
      s4_cmag_r <= s3_cmag_r;
      s4_cneg_r <= s3_cneg_r;
      s4_kind_r <= s3_kind_r;
    end
    if (adv[4]) begin
      s5_t_r <= tfull_nxt[goe_pkg::T_W-1:0];
      s5_uf_r <= tfull_nxt >= goe_pkg::PF_W'(goe_pkg::T_LIMIT);
      s5_ac_r <= s4_ac_r;
      s5_cmag_r <= s4_cmag_r;
      s5_cneg_r <= s4_cneg_r;
      s5_kind_r <= s4_kind_r;
    end
    if (adv[EXP_FIRST]) begin
      side_r[0] <= side0_nxt;
    end
    for (int j = 1; j < goe_pkg::EXP_STAGES; j++) begin
      if (adv[EXP_FIRST + j]) begin
        side_r[j] <= side_r[j-1];
      end
    end
    if (adv[12]) begin
      s13_pk0_r <= pk0_nxt;
      s13_w0_r <= 64'(sd.wmag[31:0]) * 64'(e[31:0]);
      s13_w1_r <= 38'(sd.wmag[goe_pkg::W_W-1:32]) * 38'(e[31:0]);
      s13_efull_r <= e[32];
      s13_zero_r <= sd.uf || (e == '0);
      s13_kind_r <= sd.kind;
      s13_neg_r <= sd.kind ? (sd.cneg ^ sd.wneg) : sd.cneg;
      s13_wmag_r <= sd.wmag;
      s13_ac_r <= sd.ac;
    end
    if (adv[13]) begin
      s14_mag0_r <= mag0sum_nxt[63:16];
      s14_we_r <= we_nxt;
      s14_ac_r <= s13_ac_r;
      s14_kind_r <= s13_kind_r;
      s14_neg_r <= s13_neg_r;
      s14_zero_r <= s13_zero_r;
    end
    if (adv[14]) begin
      s15_pp0_r <= 64'(s14_ac_r[31:0]) * 64'(s14_we_r[31:0]);
      s15_pp1_r <= 64'(s14_ac_r[63:32]) * 64'(s14_we_r[31:0]);
      s15_pp2_r <= 38'(s14_ac_r[31:0]) * 38'(s14_we_r[goe_pkg::W_W-1:32]);
      s15_pp3_r <= 38'(s14_ac_r[63:32]) * 38'(s14_we_r[goe_pkg::W_W-1:32]);
      s15_mag0_r <= s14_mag0_r;
      s15_kind_r <= s14_kind_r;
      s15_neg_r <= s14_neg_r;
      s15_zero_r <= s14_zero_r;
    end
    if (adv[15]) begin
      s16_mag_r <= s15_kind_r ? psum_nxt[102:31] : 72'(s15_mag0_r);
      s16_neg_r <= s15_neg_r;
      s16_zero_r <= s15_zero_r;
    end
    if (adv[16]) begin
      out_result_r <= result_nxt;
      out_sat_r <= sat_nxt;
    end
  end

  goe_exp_unit u_exp (
    .clk (clk),
    .adv (adv[EXP_FIRST +: goe_pkg::EXP_STAGES]),
    .t   (s5_t_r),
    .e   (e)
  );

  assign out_result = out_result_r;
  assign out_saturated = out_sat_r;

endmodule
